/* hw/rtl/jsu_pkg.sv */
// shared types, codes and small decode functions for the json string unescaper
// used by every module of the block; depends on nothing
package jsu_pkg;

   // result items that one text byte can cause at most
   localparam int MAX_ITEMS  = 4;
   localparam int ITEM_IDX_W = $clog2(MAX_ITEMS);

   // default depth of the queue between decode and output
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // decoder phases
   localparam logic [3:0] PH_WAIT  = 4'd0;
   localparam logic [3:0] PH_BODY  = 4'd1;
   localparam logic [3:0] PH_ESC   = 4'd2;
   localparam logic [3:0] PH_HEX0  = 4'd3;
   localparam logic [3:0] PH_HEX1  = 4'd4;
   localparam logic [3:0] PH_HEX2  = 4'd5;
   localparam logic [3:0] PH_HEX3  = 4'd6;
   localparam logic [3:0] PH_LBS   = 4'd7;
   localparam logic [3:0] PH_LU    = 4'd8;
   localparam logic [3:0] PH_LHEX0 = 4'd9;
   localparam logic [3:0] PH_LHEX1 = 4'd10;
   localparam logic [3:0] PH_LHEX2 = 4'd11;
   localparam logic [3:0] PH_LHEX3 = 4'd12;

   // result kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // error codes
   localparam logic [3:0] ERR_NONE         = 4'd0;
   localparam logic [3:0] ERR_NO_QUOTE     = 4'd1;
   localparam logic [3:0] ERR_CTRL_BYTE    = 4'd2;
   localparam logic [3:0] ERR_TRUNC_ESC    = 4'd3;
   localparam logic [3:0] ERR_BAD_HEX      = 4'd4;
   localparam logic [3:0] ERR_UNPAIRED_HI  = 4'd5;
   localparam logic [3:0] ERR_BAD_LOW_HEX  = 4'd6;
   localparam logic [3:0] ERR_UNPAIRED_LO  = 4'd7;
   localparam logic [3:0] ERR_NUL          = 4'd8;
   localparam logic [3:0] ERR_UNKNOWN_ESC  = 4'd9;
   localparam logic [3:0] ERR_UNTERMINATED = 4'd10;

   // special text bytes
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2f;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_U         = 8'h75;

   // up to four result items decoded from one text byte
   typedef struct packed {
      logic [MAX_ITEMS-1:0][7:0] data;
      logic [ITEM_IDX_W-1:0]     last_idx;
      logic [1:0]                kind;
      logic [3:0]                error_code;
   } jsu_entry_type;

   // an entry with its valid flag, between decode, queue and output
   typedef struct packed {
      logic          valid;
      jsu_entry_type entry;
   } jsu_slot_type;

   // hex digit value; bit 4 set when the byte is a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   // simple escape letter to its byte; bit 8 set for a known escape
   function automatic logic [8:0] escape_byte(input logic [7:0] b);
      logic [8:0] r;
      r = '0;
      unique case (b)
         CH_QUOTE, CH_BACKSLASH, CH_SLASH: r = {1'b1, b};
         8'h62: r = {1'b1, 8'h08};
         8'h66: r = {1'b1, 8'h0c};
         8'h6e: r = {1'b1, 8'h0a};
         8'h72: r = {1'b1, 8'h0d};
         8'h74: r = {1'b1, 8'h09};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/jsu_req_if.sv */
// request channel: one text byte per transaction
// depends on nothing
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

/* hw/rtl/jsu_rsp_if.sv */
// response channel: one decoded byte, done or error item per transaction
// depends on nothing
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic [3:0] error_code;
   logic       last;

   modport source (output valid, output out_byte, output kind, output error_code,
                   output last, input ready);
   modport sink (input valid, input out_byte, input kind, input error_code,
                 input last, output ready);
endinterface

/* hw/rtl/jsu_front.sv */
// decode front end: string phase tracking, escapes, surrogates, utf-8 encode
// depends on jsu_pkg; pushes one entry per text byte that causes results
module jsu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   output jsu_pkg::jsu_slot_type push
);
   import jsu_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] high_ff, high_in;
   logic [15:0] low_ff, low_in;

   logic [4:0]  hex;
   logic [8:0]  esc;
   logic [15:0] new_high;
   logic [15:0] new_low;
   logic [10:0] pair_top;
   logic [20:0] pair_cp;
   jsu_slot_type slot;

   // code point to one to four utf-8 bytes
   function automatic jsu_entry_type utf8_entry(input logic [20:0] cp);
      jsu_entry_type e;
      e = '0;
      e.kind = KIND_BYTE;
      e.error_code = ERR_NONE;
      if (cp < 21'h80) begin
         e.data[0] = cp[7:0];
         e.last_idx = ITEM_IDX_W'(0);
      end else if (cp < 21'h800) begin
         e.data[0] = 8'hc0 | {3'b000, cp[10:6]};
         e.data[1] = 8'h80 | {2'b00, cp[5:0]};
         e.last_idx = ITEM_IDX_W'(1);
      end else if (cp < 21'h10000) begin
         e.data[0] = 8'he0 | {4'h0, cp[15:12]};
         e.data[1] = 8'h80 | {2'b00, cp[11:6]};
         e.data[2] = 8'h80 | {2'b00, cp[5:0]};
         e.last_idx = ITEM_IDX_W'(2);
      end else begin
         e.data[0] = 8'hf0 | {5'h00, cp[20:18]};
         e.data[1] = 8'h80 | {2'b00, cp[17:12]};
         e.data[2] = 8'h80 | {2'b00, cp[11:6]};
         e.data[3] = 8'h80 | {2'b00, cp[5:0]};
         e.last_idx = ITEM_IDX_W'(3);
      end
      return e;
   endfunction

   // single item entry
   function automatic jsu_entry_type one_item(input logic [7:0] b, input logic [1:0] k,
                                              input logic [3:0] code);
      jsu_entry_type e;
      e = '0;
      e.data[0] = b;
      e.last_idx = ITEM_IDX_W'(0);
      e.kind = k;
      e.error_code = code;
      return e;
   endfunction

   // per-byte helpers
   assign hex      = hex_value(in_byte);
   assign esc      = escape_byte(in_byte);
   assign new_high = {high_ff[11:0], hex[3:0]};
   assign new_low  = {low_ff[11:0], hex[3:0]};
   // 0x10000 + (high - 0xd800) * 1024 + (low - 0xdc00)
   assign pair_top = {1'b0, high_ff[9:0]} + 11'h040;
   assign pair_cp  = {pair_top, new_low[9:0]};

   // next phase and result entry for an accepted byte
   always_comb begin
      phase_in = phase_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      slot     = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_BODY: begin
               if (in_byte == CH_NUL) begin
                  phase_in = PH_WAIT;
                  slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_UNTERMINATED)};
               end else if (in_byte == CH_QUOTE) begin
                  phase_in = PH_WAIT;
                  slot = {1'b1, one_item(8'h00, KIND_DONE, ERR_NONE)};
               end else if (in_byte < CH_SPACE) begin
                  phase_in = PH_WAIT;
                  slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_CTRL_BYTE)};
               end else if (in_byte == CH_BACKSLASH) begin
                  phase_in = PH_ESC;
               end else begin
                  slot = {1'b1, one_item(in_byte, KIND_BYTE, ERR_NONE)};
               end
            end
            PH_ESC: begin
               if (in_byte == CH_NUL) begin
                  phase_in = PH_WAIT;
                  slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_TRUNC_ESC)};
               end else if (in_byte == CH_U) begin
                  high_in  = '0;
                  phase_in = PH_HEX0;
               end else if (esc[8]) begin
                  phase_in = PH_BODY;
                  slot = {1'b1, one_item(esc[7:0], KIND_BYTE, ERR_NONE)};
               end else begin
                  phase_in = PH_WAIT;
                  slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_UNKNOWN_ESC)};
               end
            end
            PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
               if (!hex[4]) begin
                  phase_in = PH_WAIT;
                  slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_BAD_HEX)};
               end else begin
                  high_in = new_high;
                  if (phase_ff != PH_HEX3) begin
                     phase_in = phase_ff + 4'd1;
                  end else if (new_high >= 16'hd800 && new_high <= 16'hdbff) begin
                     phase_in = PH_LBS;
                  end else if (new_high >= 16'hdc00 && new_high <= 16'hdfff) begin
                     phase_in = PH_WAIT;
                     slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_UNPAIRED_LO)};
                  end else if (new_high == 16'h0000) begin
                     phase_in = PH_WAIT;
                     slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_NUL)};
                  end else begin
                     phase_in = PH_BODY;
                     slot = {1'b1, utf8_entry({5'h00, new_high})};
                  end
               end
            end
            PH_LBS: begin
               if (in_byte == CH_BACKSLASH) begin
                  phase_in = PH_LU;
               end else begin
                  phase_in = PH_WAIT;
                  slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_UNPAIRED_HI)};
               end
            end
            PH_LU: begin
               if (in_byte == CH_U) begin
                  low_in   = '0;
                  phase_in = PH_LHEX0;
               end else begin
                  phase_in = PH_WAIT;
                  slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_UNPAIRED_HI)};
               end
            end
            PH_LHEX0, PH_LHEX1, PH_LHEX2, PH_LHEX3: begin
               if (!hex[4]) begin
                  phase_in = PH_WAIT;
                  slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_BAD_LOW_HEX)};
               end else begin
                  low_in = new_low;
                  if (phase_ff != PH_LHEX3) begin
                     phase_in = phase_ff + 4'd1;
                  end else if (new_low < 16'hdc00 || new_low > 16'hdfff) begin
                     phase_in = PH_WAIT;
                     slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_UNPAIRED_HI)};
                  end else begin
                     phase_in = PH_BODY;
                     slot = {1'b1, utf8_entry(pair_cp)};
                  end
               end
            end
            // waiting for the opening quote, also the unused phase codes
            default: begin
               if (in_byte == CH_QUOTE) begin
                  phase_in = PH_BODY;
               end else begin
                  phase_in = PH_WAIT;
                  slot = {1'b1, one_item(8'h00, KIND_ERR, ERR_NO_QUOTE)};
               end
            end
         endcase
      end
   end

   assign push = slot;

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         high_ff  <= '0;
         low_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
      end
   end

endmodule

/* hw/rtl/jsu_queue.sv */
// short entry queue between the decode front end and the output back end
// depends on jsu_pkg
module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  jsu_pkg::jsu_slot_type push,
   output logic                 push_ready,
   output jsu_pkg::jsu_slot_type head,
   input  logic                 pop
);
   import jsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_entry_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head       = {count_ff != '0, mem_ff[rd_ptr_ff]};

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

/* hw/rtl/jsu_back.sv */
// output back end: walks the items of the head entry into the response register
// depends on jsu_pkg
module jsu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  jsu_pkg::jsu_slot_type head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic [1:0]           rsp_kind,
   output logic [3:0]           rsp_error_code,
   output logic                 rsp_last
);
   import jsu_pkg::*;

   logic [ITEM_IDX_W-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff;
   logic [1:0]            kind_ff;
   logic [3:0]            code_ff;
   logic                  last_ff;
   logic                  load;
   logic                  at_last;

   // output register takes a new item when empty or being drained
   assign load    = head.valid && (!valid_ff || rsp_ready);
   assign at_last = (idx_ff == head.entry.last_idx);
   assign pop     = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_last ? '0 : idx_ff + ITEM_IDX_W'(1);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head.entry.data[idx_ff];
         kind_ff <= head.entry.kind;
         code_ff <= head.entry.error_code;
         last_ff <= at_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_error_code = code_ff;
   assign rsp_last       = last_ff;

endmodule

/* hw/rtl/json_string_unescape_utf8.sv */
// channel  dir  handshake      payload
// req      in   valid/ready    in_byte[7:0]
// rsp      out  valid/ready    out_byte[7:0] kind[1:0] error_code[3:0] last
//
// one text byte is accepted per cycle while the entry queue has room
// a surrogate pair gives up to four response transactions
// the first response of a text byte passes through the entry queue, then the response register
// synchronous reset puts the decoder in the wait-for-quote phase and empties the queue
// response stalls fill the queue; req.ready drops only when it is full
module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   jsu_req_if.sink   req,
   jsu_rsp_if.source rsp
);
   import jsu_pkg::*;

   jsu_slot_type push;
   jsu_slot_type head;
   logic         push_ready;
   logic         pop;
   logic         accept;

   // input transaction
   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   jsu_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req.in_byte),
      .push    (push)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_out_byte   (rsp.out_byte),
      .rsp_kind       (rsp.kind),
      .rsp_error_code (rsp.error_code),
      .rsp_last       (rsp.last)
   );

`ifndef ASSERT_OFF
   // the front end never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> push_ready)
      else $error("entry pushed into full queue");

   // a done item closes its transaction group and carries no error code
   a_done_item: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.kind == KIND_DONE) |-> (rsp.last && rsp.error_code == ERR_NONE
                                               && rsp.out_byte == 8'h00))
      else $error("malformed done item");

   // an error item is alone and carries a nonzero code
   a_error_item: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.kind == KIND_ERR) |-> (rsp.last && rsp.error_code != ERR_NONE))
      else $error("malformed error item");

   // a popped entry was really present
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");
`endif

endmodule

/* tb/sv/json_string_unescape_utf8_test.sv */
// self-checking testbench for json_string_unescape_utf8: directed table, then random strings
// depends on jsu_pkg, jsu_req_if, jsu_rsp_if and the json_string_unescape_utf8 rtl
module json_string_unescape_utf8_test;
   import jsu_pkg::*;

   localparam int STIM_ITEMS     = 360;
   localparam int QUIET_AFTER    = 300;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_REPORTS    = 10;
   localparam int DIRECTED_ROWS  = 27;

   // escape letters and surrogate bounds
   localparam logic [7:0]  CH_LOWER_B    = 8'h62;
   localparam logic [7:0]  CH_LOWER_F    = 8'h66;
   localparam logic [7:0]  CH_LOWER_N    = 8'h6e;
   localparam logic [7:0]  CH_LOWER_R    = 8'h72;
   localparam logic [7:0]  CH_LOWER_T    = 8'h74;
   localparam logic [15:0] SURR_HIGH_MIN = 16'hd800;
   localparam logic [15:0] SURR_HIGH_MAX = 16'hdbff;
   localparam logic [15:0] SURR_LOW_MIN  = 16'hdc00;
   localparam logic [15:0] SURR_LOW_MAX  = 16'hdfff;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [3:0] error_code;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] text;
      bit         typed;
      logic [1:0] kind;
      logic [3:0] code;
      logic [7:0] out_byte;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   jsu_req_if req_ch ();
   jsu_rsp_if rsp_ch ();

   json_string_unescape_utf8 dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #2 clock = ~clock;

   // decoder state mirrored by the predictor
   logic [3:0]  scan_phase = PH_WAIT;
   logic [15:0] high_unit  = '0;
   logic [15:0] low_unit   = '0;

   rsp_item_type step_items [$];
   rsp_item_type decoded_due [$];
   logic [7:0]   text_q [$];
   logic [7:0]   esc_letters [8];
   dir_row_type  directed_rows [DIRECTED_ROWS];

   int           text_sent    = 0;
   int           fail_count   = 0;
   int           stall_cycles = 0;
   int           src_gap_pct  = 20;
   int           sink_gap_pct = 20;
   bit           row_typed    = 1'b0;
   rsp_item_type row_item     = '0;

   function automatic int hex_nibble(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
      if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
      if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
      return -1;
   endfunction

   function automatic void put_item(input logic [7:0] b, input logic [1:0] k,
                                    input logic [3:0] c);
      rsp_item_type it;
      it.out_byte   = b;
      it.kind       = k;
      it.error_code = c;
      it.last       = 1'b0;
      step_items.push_back(it);
   endfunction

   function automatic void abort_string(input logic [3:0] c);
      scan_phase = PH_WAIT;
      put_item(8'h00, KIND_ERR, c);
   endfunction

   function automatic void emit_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         put_item(cp[7:0], KIND_BYTE, ERR_NONE);
      end else if (cp < 21'h800) begin
         put_item({3'b110, cp[10:6]}, KIND_BYTE, ERR_NONE);
         put_item({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
      end else if (cp < 21'h10000) begin
         put_item({4'b1110, cp[15:12]}, KIND_BYTE, ERR_NONE);
         put_item({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
         put_item({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
      end else begin
         put_item({5'b11110, cp[20:18]}, KIND_BYTE, ERR_NONE);
         put_item({2'b10, cp[17:12]}, KIND_BYTE, ERR_NONE);
         put_item({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
         put_item({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
      end
   endfunction

   // predicts the result items of one text byte into step_items
   function automatic void unescape_byte(input logic [7:0] b);
      int           h;
      logic [20:0]  cp;
      rsp_item_type it;
      step_items.delete();
      h = hex_nibble(b);
      case (scan_phase)
         PH_BODY: begin
            if (b == CH_NUL) abort_string(ERR_UNTERMINATED);
            else if (b == CH_QUOTE) begin
               scan_phase = PH_WAIT;
               put_item(8'h00, KIND_DONE, ERR_NONE);
            end else if (b < CH_SPACE) abort_string(ERR_CTRL_BYTE);
            else if (b == CH_BACKSLASH) scan_phase = PH_ESC;
            else put_item(b, KIND_BYTE, ERR_NONE);
         end
         PH_ESC: begin
            case (b)
               CH_NUL: abort_string(ERR_TRUNC_ESC);
               CH_U: begin
                  high_unit  = '0;
                  scan_phase = PH_HEX0;
               end
               CH_QUOTE, CH_BACKSLASH, CH_SLASH: begin
                  scan_phase = PH_BODY;
                  put_item(b, KIND_BYTE, ERR_NONE);
               end
               CH_LOWER_B, CH_LOWER_F, CH_LOWER_N, CH_LOWER_R, CH_LOWER_T: begin
                  scan_phase = PH_BODY;
                  case (b)
                     CH_LOWER_B: put_item(8'h08, KIND_BYTE, ERR_NONE);
                     CH_LOWER_F: put_item(8'h0c, KIND_BYTE, ERR_NONE);
                     CH_LOWER_N: put_item(8'h0a, KIND_BYTE, ERR_NONE);
                     CH_LOWER_R: put_item(8'h0d, KIND_BYTE, ERR_NONE);
                     default:    put_item(8'h09, KIND_BYTE, ERR_NONE);
                  endcase
               end
               default: abort_string(ERR_UNKNOWN_ESC);
            endcase
         end
         PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
            if (h < 0) begin
               abort_string(ERR_BAD_HEX);
            end else begin
               high_unit = {high_unit[11:0], 4'(h)};
               if (scan_phase != PH_HEX3) begin
                  scan_phase = scan_phase + 4'd1;
               end else if (high_unit >= SURR_HIGH_MIN && high_unit <= SURR_HIGH_MAX) begin
                  scan_phase = PH_LBS;
               end else if (high_unit >= SURR_LOW_MIN && high_unit <= SURR_LOW_MAX) begin
                  abort_string(ERR_UNPAIRED_LO);
               end else if (high_unit == 16'h0000) begin
                  abort_string(ERR_NUL);
               end else begin
                  scan_phase = PH_BODY;
                  emit_code_point({5'd0, high_unit});
               end
            end
         end
         PH_LBS: begin
            if (b == CH_BACKSLASH) scan_phase = PH_LU;
            else abort_string(ERR_UNPAIRED_HI);
         end
         PH_LU: begin
            if (b == CH_U) begin
               low_unit   = '0;
               scan_phase = PH_LHEX0;
            end else abort_string(ERR_UNPAIRED_HI);
         end
         PH_LHEX0, PH_LHEX1, PH_LHEX2, PH_LHEX3: begin
            if (h < 0) begin
               abort_string(ERR_BAD_LOW_HEX);
            end else begin
               low_unit = {low_unit[11:0], 4'(h)};
               if (scan_phase != PH_LHEX3) begin
                  scan_phase = scan_phase + 4'd1;
               end else if (low_unit < SURR_LOW_MIN || low_unit > SURR_LOW_MAX) begin
                  abort_string(ERR_UNPAIRED_HI);
               end else begin
                  // join the pair into one supplementary code point
                  cp = 21'h10000 + (21'(high_unit - SURR_HIGH_MIN) << 10)
                       + 21'(low_unit - SURR_LOW_MIN);
                  scan_phase = PH_BODY;
                  emit_code_point(cp);
               end
            end
         end
         default: begin
            if (b == CH_QUOTE) scan_phase = PH_BODY;
            else abort_string(ERR_NO_QUOTE);
         end
      endcase
      if (step_items.size() > 0) begin
         it      = step_items.pop_back();
         it.last = 1'b1;
         step_items.push_back(it);
      end
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   // request transactions feed the predictor, response transactions are checked
   always @(posedge clock) begin : track_channels
      rsp_item_type got;
      rsp_item_type want;
      bit           moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            unescape_byte(req_ch.in_byte);
            if (row_typed) decoded_due.push_back(row_item);
            else foreach (step_items[i]) decoded_due.push_back(step_items[i]);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved          = 1'b1;
            got.out_byte   = rsp_ch.out_byte;
            got.kind       = rsp_ch.kind;
            got.error_code = rsp_ch.error_code;
            got.last       = rsp_ch.last;
            if (decoded_due.size() == 0) begin
               note_failure($sformatf("unexpected result: byte %02h kind %0d code %0d last %0d",
                                      got.out_byte, got.kind, got.error_code, got.last));
            end else begin
               want = decoded_due.pop_front();
               if (got !== want)
                  note_failure($sformatf("mismatch: expected %s, got %s",
                     $sformatf("byte %02h kind %0d code %0d last %0d",
                               want.out_byte, want.kind, want.error_code, want.last),
                     $sformatf("byte %02h kind %0d code %0d last %0d",
                               got.out_byte, got.kind, got.error_code, got.last)));
            end
         end
         // watchdog on cycles with no transaction on either channel
         if (moved) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
               $display("Verification failed");
               $finish;
            end
         end
      end
   end

   // response side: random stall bursts until the quiet tail
   initial begin : rsp_sink
      int hold;
      hold         = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else if (text_sent < QUIET_AFTER && $urandom_range(1, 100) <= sink_gap_pct) begin
            hold         = $urandom_range(1, 7) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // one request transaction, called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input bit typed,
                            input rsp_item_type typed_item);
      if (text_sent < QUIET_AFTER && $urandom_range(1, 100) <= src_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      row_typed = typed;
      row_item  = typed_item;
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      text_sent++;
      @(negedge clock);
   endtask

   function automatic void add_hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) text_q.push_back(8'h30 + 8'(nib));
      else if ($urandom_range(0, 1) == 1) text_q.push_back(8'h41 + 8'(nib) - 8'd10);
      else text_q.push_back(8'h61 + 8'(nib) - 8'd10);
   endfunction

   function automatic void add_hex4(input logic [15:0] v);
      text_q.push_back(CH_BACKSLASH);
      text_q.push_back(CH_U);
      for (int i = 3; i >= 0; i--) add_hex_digit(v[i*4 +: 4]);
   endfunction

   function automatic logic [7:0] pick_non_hex();
      logic [7:0] b;
      if ($urandom_range(0, 3) == 0) return CH_NUL;
      do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) >= 0);
      return b;
   endfunction

   function automatic logic [15:0] pick_high_unit();
      return 16'($urandom_range(SURR_HIGH_MIN, SURR_HIGH_MAX));
   endfunction

   // one valid element of a string body
   function automatic void add_element();
      logic [7:0]  b;
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            do b = 8'($urandom_range(CH_SPACE, 255));
            while (b == CH_QUOTE || b == CH_BACKSLASH);
            text_q.push_back(b);
         end
         4, 5: begin
            text_q.push_back(CH_BACKSLASH);
            text_q.push_back(esc_letters[$urandom_range(0, 7)]);
         end
         6, 7: begin
            case ($urandom_range(0, 5))
               0: v = 16'($urandom_range(1, 16'h7f));
               1: v = 16'($urandom_range(16'h80, 16'h7ff));
               2: v = 16'($urandom_range(16'h800, 16'hd7ff));
               3: v = 16'($urandom_range(16'he000, 16'hffff));
               4: v = ($urandom_range(0, 1) == 1) ? 16'h0001 : 16'hffff;
               default: begin
                  case ($urandom_range(0, 5))
                     0: v = 16'h007f;
                     1: v = 16'h0080;
                     2: v = 16'h07ff;
                     3: v = 16'h0800;
                     4: v = 16'hd7ff;
                     default: v = 16'he000;
                  endcase
               end
            endcase
            add_hex4(v);
         end
         default: begin
            add_hex4(pick_high_unit());
            add_hex4(16'($urandom_range(SURR_LOW_MIN, SURR_LOW_MAX)));
         end
      endcase
   endfunction

   // one broken element that ends the string in an error
   function automatic void add_fault();
      logic [7:0]  b;
      logic [15:0] v;
      int          k;
      k = $urandom_range(0, 3);
      case ($urandom_range(0, 10))
         0: text_q.push_back(8'($urandom_range(1, CH_SPACE - 1)));
         1: begin
            text_q.push_back(CH_BACKSLASH);
            do b = 8'($urandom_range(0, 255));
            while (b == CH_NUL || b == CH_U || b == CH_QUOTE || b == CH_BACKSLASH ||
                   b == CH_SLASH || b == CH_LOWER_B || b == CH_LOWER_F ||
                   b == CH_LOWER_N || b == CH_LOWER_R || b == CH_LOWER_T);
            text_q.push_back(b);
         end
         2: begin
            text_q.push_back(CH_BACKSLASH);
            text_q.push_back(CH_NUL);
         end
         3: text_q.push_back(CH_NUL);
         4: begin
            text_q.push_back(CH_BACKSLASH);
            text_q.push_back(CH_U);
            repeat (k) add_hex_digit(4'($urandom_range(0, 15)));
            text_q.push_back(pick_non_hex());
         end
         5: add_hex4(16'($urandom_range(SURR_LOW_MIN, SURR_LOW_MAX)));
         6: add_hex4(16'h0000);
         7: begin
            add_hex4(pick_high_unit());
            do b = 8'($urandom_range(0, 255)); while (b == CH_BACKSLASH);
            text_q.push_back(b);
         end
         8: begin
            add_hex4(pick_high_unit());
            text_q.push_back(CH_BACKSLASH);
            do b = 8'($urandom_range(0, 255)); while (b == CH_U);
            text_q.push_back(b);
         end
         9: begin
            add_hex4(pick_high_unit());
            text_q.push_back(CH_BACKSLASH);
            text_q.push_back(CH_U);
            repeat (k) add_hex_digit(4'($urandom_range(0, 15)));
            text_q.push_back(pick_non_hex());
         end
         default: begin
            add_hex4(pick_high_unit());
            do v = 16'($urandom_range(0, 16'hffff));
            while (v >= SURR_LOW_MIN && v <= SURR_LOW_MAX);
            add_hex4(v);
         end
      endcase
   endfunction

   // next random text: well-formed strings half the time, else broken ones or some noise
   function automatic void build_text();
      int         r;
      logic [7:0] b;
      text_q.delete();
      case ($urandom_range(0, 2))
         0: src_gap_pct = 0;
         1: src_gap_pct = 10;
         default: src_gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
         0: sink_gap_pct = 0;
         1: sink_gap_pct = 10;
         default: sink_gap_pct = 35;
      endcase
      r = $urandom_range(0, 9);
      if (r == 0) begin
         repeat ($urandom_range(1, 3)) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
            text_q.push_back(b);
         end
      end else if (r <= 4) begin
         text_q.push_back(CH_QUOTE);
         repeat ($urandom_range(0, 3)) add_element();
         add_fault();
      end else begin
         text_q.push_back(CH_QUOTE);
         repeat ($urandom_range(0, 4)) add_element();
         text_q.push_back(CH_QUOTE);
      end
   endfunction

   initial begin : stimulus
      rsp_item_type want;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'h00;
      esc_letters    = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_LOWER_B,
                         CH_LOWER_F, CH_LOWER_N, CH_LOWER_R, CH_LOWER_T};
      // typed rows carry their single result; the others go through the predictor
      directed_rows = '{
         '{CH_NUL,       1'b1, KIND_ERR,  ERR_NO_QUOTE,     8'h00},
         '{8'hff,        1'b1, KIND_ERR,  ERR_NO_QUOTE,     8'h00},
         '{CH_QUOTE,     1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{CH_SPACE,     1'b1, KIND_BYTE, ERR_NONE,         8'h20},
         '{8'hff,        1'b1, KIND_BYTE, ERR_NONE,         8'hff},
         '{8'h1f,        1'b1, KIND_ERR,  ERR_CTRL_BYTE,    8'h00},
         '{CH_QUOTE,     1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{CH_BACKSLASH, 1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{CH_LOWER_N,   1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         // surrogate pair d83d de00, mixed-case hex
         '{CH_BACKSLASH, 1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{CH_U,         1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{8'h64,        1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{8'h38,        1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{8'h33,        1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{8'h44,        1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{CH_BACKSLASH, 1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{CH_U,         1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{8'h64,        1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{8'h45,        1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{8'h30,        1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{8'h30,        1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{CH_QUOTE,     1'b1, KIND_DONE, ERR_NONE,         8'h00},
         // end of text right after a backslash, then inside the body
         '{CH_QUOTE,     1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{CH_BACKSLASH, 1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{CH_NUL,       1'b1, KIND_ERR,  ERR_TRUNC_ESC,    8'h00},
         '{CH_QUOTE,     1'b0, KIND_BYTE, ERR_NONE,         8'h00},
         '{CH_NUL,       1'b1, KIND_ERR,  ERR_UNTERMINATED, 8'h00}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         want.out_byte   = directed_rows[i].out_byte;
         want.kind       = directed_rows[i].kind;
         want.error_code = directed_rows[i].code;
         want.last       = 1'b1;
         send_byte(directed_rows[i].text, directed_rows[i].typed, want);
      end

      // random strings
      while (text_sent < STIM_ITEMS) begin
         build_text();
         foreach (text_q[i]) send_byte(text_q[i], 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      while (decoded_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
